>>> rtl/hwfk_pkg.sv
package hwfk_pkg;

    localparam logic [15:0] HALF_FIRST  = 16'hFF61;
    localparam logic [15:0] HALF_LAST   = 16'hFF9F;
    localparam logic [15:0] MARK_VOICED = 16'hFF9E;
    localparam logic [15:0] MARK_SEMI   = 16'hFF9F;
    localparam logic [15:0] ASCII_FIRST = 16'h0020;
    localparam logic [15:0] ASCII_LAST  = 16'h007E;
    localparam logic [15:0] ASCII_SHIFT = 16'hFEE0;

    localparam logic [1:0] MARKS_NONE   = 2'b00;
    localparam logic [1:0] MARKS_VOICED = 2'b01;
    localparam logic [1:0] MARKS_BOTH   = 2'b11;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        valid;
        logic [15:0] kana;
        logic [1:0]  marks;
    } held_t;

    typedef struct packed {
        logic [1:0]  num;
        logic [15:0] code0;
        logic        last0;
        logic [15:0] code1;
    } result_t;

    function automatic logic [15:0] kana_full(input logic [5:0] idx);
        logic [15:0] k;
        case (idx)
            6'd0:  k = 16'h3002;
            6'd1:  k = 16'h300C;
            6'd2:  k = 16'h300D;
            6'd3:  k = 16'h3001;
            6'd4:  k = 16'h30FB;
            6'd5:  k = 16'h30F2;
            6'd6:  k = 16'h30A1;
            6'd7:  k = 16'h30A3;
            6'd8:  k = 16'h30A5;
            6'd9:  k = 16'h30A7;
            6'd10: k = 16'h30A9;
            6'd11: k = 16'h30E3;
            6'd12: k = 16'h30E5;
            6'd13: k = 16'h30E7;
            6'd14: k = 16'h30C3;
            6'd15: k = 16'h30FC;
            6'd16: k = 16'h30A2;
            6'd17: k = 16'h30A4;
            6'd18: k = 16'h30A6;
            6'd19: k = 16'h30A8;
            6'd20: k = 16'h30AA;
            6'd21: k = 16'h30AB;
            6'd22: k = 16'h30AD;
            6'd23: k = 16'h30AF;
            6'd24: k = 16'h30B1;
            6'd25: k = 16'h30B3;
            6'd26: k = 16'h30B5;
            6'd27: k = 16'h30B7;
            6'd28: k = 16'h30B9;
            6'd29: k = 16'h30BB;
            6'd30: k = 16'h30BD;
            6'd31: k = 16'h30BF;
            6'd32: k = 16'h30C1;
            6'd33: k = 16'h30C4;
            6'd34: k = 16'h30C6;
            6'd35: k = 16'h30C8;
            6'd36: k = 16'h30CA;
            6'd37: k = 16'h30CB;
            6'd38: k = 16'h30CC;
            6'd39: k = 16'h30CD;
            6'd40: k = 16'h30CE;
            6'd41: k = 16'h30CF;
            6'd42: k = 16'h30D2;
            6'd43: k = 16'h30D5;
            6'd44: k = 16'h30D8;
            6'd45: k = 16'h30DB;
            6'd46: k = 16'h30DE;
            6'd47: k = 16'h30DF;
            6'd48: k = 16'h30E0;
            6'd49: k = 16'h30E1;
            6'd50: k = 16'h30E2;
            6'd51: k = 16'h30E4;
            6'd52: k = 16'h30E6;
            6'd53: k = 16'h30E8;
            6'd54: k = 16'h30E9;
            6'd55: k = 16'h30EA;
            6'd56: k = 16'h30EB;
            6'd57: k = 16'h30EC;
            6'd58: k = 16'h30ED;
            6'd59: k = 16'h30EF;
            6'd60: k = 16'h30F3;
            6'd61: k = 16'h309B;
            6'd62: k = 16'h309C;
            default: k = 16'h309C;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] marks_of(input logic [5:0] idx);
        logic [1:0] m;
        if (idx >= 6'd21 && idx <= 6'd35)
        begin
            m = MARKS_VOICED;
        end
        else if (idx >= 6'd41 && idx <= 6'd45)
        begin
            m = MARKS_BOTH;
        end
        else
        begin
            m = MARKS_NONE;
        end
        return m;
    endfunction

    function automatic logic [15:0] ascii_full(input logic [15:0] c);
        logic [15:0] f;
        case (c)
            16'h0020: f = 16'h3000;
            16'h0022: f = 16'h201D;
            16'h0027: f = 16'h2019;
            16'h002D: f = 16'h2010;
            16'h005C: f = 16'hFFE5;
            16'h007E: f = 16'h301C;
            default:  f = c + ASCII_SHIFT;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/hwfk_conv.sv
module hwfk_conv (
    input  logic                 ansi_mode,
    input  logic [15:0]          code_unit,
    input  logic                 end_of_text,
    input  hwfk_pkg::held_t      held,
    output hwfk_pkg::held_t      held_next,
    output hwfk_pkg::result_t    result
);

    logic        merge_voiced;
    logic        merge_semi;
    logic        is_ascii;
    logic        is_half;
    logic [5:0]  idx;
    logic [15:0] kana;
    logic [1:0]  marks;
    logic        hold_now;
    logic [15:0] cur_code;

    always_comb
    begin
        merge_voiced = held.valid && (code_unit == hwfk_pkg::MARK_VOICED);
        merge_semi   = held.valid && (code_unit == hwfk_pkg::MARK_SEMI) && held.marks[1];
        is_ascii     = ansi_mode && (code_unit >= hwfk_pkg::ASCII_FIRST)
                       && (code_unit <= hwfk_pkg::ASCII_LAST);
        is_half      = (code_unit >= hwfk_pkg::HALF_FIRST)
                       && (code_unit <= hwfk_pkg::HALF_LAST);
        idx          = 6'(code_unit - hwfk_pkg::HALF_FIRST);
        kana         = hwfk_pkg::kana_full(idx);
        marks        = hwfk_pkg::marks_of(idx);
        hold_now     = !is_ascii && is_half && (marks != hwfk_pkg::MARKS_NONE) && !end_of_text;

        if (is_ascii)
        begin
            cur_code = hwfk_pkg::ascii_full(code_unit);
        end
        else if (is_half)
        begin
            cur_code = kana;
        end
        else
        begin
            cur_code = code_unit;
        end

        held_next = '0;
        result    = '0;

        if (merge_voiced || merge_semi)
        begin
            result.num   = 2'd1;
            result.code0 = held.kana + (merge_voiced ? 16'd1 : 16'd2);
            result.last0 = 1'b1;
        end
        else
        begin
            if (hold_now)
            begin
                held_next.valid = 1'b1;
                held_next.kana  = kana;
                held_next.marks = marks;
            end
            if (held.valid)
            begin
                result.code0 = held.kana;
                result.code1 = cur_code;
                result.num   = hold_now ? 2'd1 : 2'd2;
                result.last0 = hold_now;
            end
            else
            begin
                result.code0 = cur_code;
                result.num   = hold_now ? 2'd0 : 2'd1;
                result.last0 = 1'b1;
            end
        end
    end

endmodule

>>> rtl/halfwidth_to_fullwidth_kana.sv
// halfwidth to fullwidth katakana stream converter
// s_tdata carries one utf-16 code unit per transfer, s_tlast marks end of text.
// m_tdata carries converted code units, m_tlast marks the final result of an input.
// cfg_valid/cfg_data write ansi_mode (printable ascii to fullwidth); write only when idle.
// an input transfer lands in an input register; once the fifo has two free slots
// the conversion logic turns it into zero, one or two results pushed into a
// 4-entry output fifo that drives m_*. throughput is one code unit per cycle
// while each yields at most one result and the receiver takes every result;
// a unit that releases a held kana plus itself yields two results for m_*.
// a combinable kana is held until the next unit, which may merge with it;
// with s_tlast set nothing stays held.
// when the receiver stalls the fifo fills and s_tready drops once fewer than
// two slots are free; nothing is lost.
// reset clears ansi_mode, the held kana, the input valid flag, fifo pointers and count.
module halfwidth_to_fullwidth_kana (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // code_unit
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_code
    output logic        m_tlast    // last_of_run
);

    logic                        ansi_mode_reg;
    logic                        in_valid_reg;
    logic [15:0]                 in_code_reg;
    logic                        in_eot_reg;
    hwfk_pkg::held_t             held_reg;
    hwfk_pkg::held_t             held_next;
    hwfk_pkg::result_t           result;
    logic [16:0]                 fifo_reg [hwfk_pkg::FIFO_DEPTH];
    logic [hwfk_pkg::PTR_W-1:0]  wr_ptr_reg;
    logic [hwfk_pkg::PTR_W-1:0]  rd_ptr_reg;
    logic [hwfk_pkg::CNT_W-1:0]  count_reg;
    logic [hwfk_pkg::CNT_W-1:0]  count_next;
    logic [hwfk_pkg::CNT_W-1:0]  push_num;
    logic                        advance;
    logic                        pop;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg
                       && (count_reg <= hwfk_pkg::CNT_W'(hwfk_pkg::FIFO_DEPTH - 2));
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = (count_reg != '0);
    assign pop       = m_tvalid && m_tready;
    assign m_tdata   = fifo_reg[rd_ptr_reg][15:0];
    assign m_tlast   = fifo_reg[rd_ptr_reg][16];
    assign push_num  = advance ? hwfk_pkg::CNT_W'(result.num) : '0;
    assign count_next = count_reg + push_num - (pop ? hwfk_pkg::CNT_W'(1) : '0);

    hwfk_conv u_conv (
        .ansi_mode   (ansi_mode_reg),
        .code_unit   (in_code_reg),
        .end_of_text (in_eot_reg),
        .held        (held_reg),
        .held_next   (held_next),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ansi_mode_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            held_reg      <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ansi_mode_reg <= cfg_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                held_reg   <= held_next;
                wr_ptr_reg <= wr_ptr_reg + hwfk_pkg::PTR_W'(result.num);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + hwfk_pkg::PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_code_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
        if (advance && (result.num != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= {result.last0, result.code0};
        end
        if (advance && (result.num == 2'd2))
        begin
            fifo_reg[wr_ptr_reg + hwfk_pkg::PTR_W'(1)] <= {1'b1, result.code1};
        end
    end

`ifndef NO_ASSERTIONS
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hwfk_pkg::CNT_W'(hwfk_pkg::FIFO_DEPTH))
        else $error("output fifo overflow");

    a_held_marks: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg.valid |-> (held_reg.marks != hwfk_pkg::MARKS_NONE))
        else $error("held kana without marks");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg.valid |-> (held_reg.kana >= 16'h30AB && held_reg.kana <= 16'h30DB))
        else $error("held kana outside voiceable range");

    a_eot_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eot_reg) |=> !held_reg.valid)
        else $error("kana still held after end of text");
`endif

endmodule

>>> sim/tb_halfwidth_to_fullwidth_kana.sv
`timescale 1ns / 100ps

module tb_halfwidth_to_fullwidth_kana;

    typedef struct packed {
        logic [15:0] code;
        logic        last;
    } fw_unit_t;

    class kana_scoreboard;
        bit          ansi;
        bit          held_valid;
        logic [15:0] held_kana;
        logic [1:0]  held_marks;
        fw_unit_t    pending[$];
        int          errors;

        function new();
            ansi = 0;
            held_valid = 0;
            held_kana = '0;
            held_marks = '0;
            errors = 0;
        endfunction

        function logic [15:0] fullwidth_kana(input int idx);
            if (idx <= 5)
            begin
                case (idx)
                    0: return 16'h3002;
                    1: return 16'h300C;
                    2: return 16'h300D;
                    3: return 16'h3001;
                    4: return 16'h30FB;
                    default: return 16'h30F2;
                endcase
            end
            if (idx <= 10) return 16'(16'h30A1 + 2 * (idx - 6));
            if (idx <= 13) return 16'(16'h30E3 + 2 * (idx - 11));
            if (idx == 14) return 16'h30C3;
            if (idx == 15) return 16'h30FC;
            if (idx <= 20) return 16'(16'h30A2 + 2 * (idx - 16));
            if (idx <= 32) return 16'(16'h30AB + 2 * (idx - 21));
            if (idx <= 35) return 16'(16'h30C4 + 2 * (idx - 33));
            if (idx <= 40) return 16'(16'h30CA + (idx - 36));
            if (idx <= 45) return 16'(16'h30CF + 3 * (idx - 41));
            if (idx <= 50) return 16'(16'h30DE + (idx - 46));
            if (idx <= 53) return 16'(16'h30E4 + 2 * (idx - 51));
            if (idx <= 58) return 16'(16'h30E9 + (idx - 54));
            if (idx == 59) return 16'h30EF;
            if (idx == 60) return 16'h30F3;
            if (idx == 61) return 16'h309B;
            return 16'h309C;
        endfunction

        // bit 0: voiced mark combines, bit 1: semi-voiced mark combines
        function logic [1:0] kana_marks(input int idx);
            if (idx >= 21 && idx <= 35) return 2'b01;
            if (idx >= 41 && idx <= 45) return 2'b11;
            return 2'b00;
        endfunction

        function logic [15:0] fullwidth_ascii(input logic [15:0] c);
            case (c)
                16'h0020: return 16'h3000;
                16'h0022: return 16'h201D;
                16'h0027: return 16'h2019;
                16'h002D: return 16'h2010;
                16'h005C: return 16'hFFE5;
                16'h007E: return 16'h301C;
                default:  return c - 16'h0021 + 16'hFF01;
            endcase
        endfunction

        function void note_unit(input logic [15:0] c, input logic eot);
            logic [15:0] outs [0:1];
            int          n;
            int          idx;
            logic [1:0]  m;
            n = 0;
            if (held_valid)
            begin
                if (c == hwfk_pkg::MARK_VOICED
                    || (c == hwfk_pkg::MARK_SEMI && held_marks[1]))
                begin
                    pending.push_back('{held_kana
                        + (c == hwfk_pkg::MARK_VOICED ? 16'd1 : 16'd2), 1'b1});
                    held_valid = 0;
                    held_kana = '0;
                    held_marks = '0;
                    return;
                end
                outs[n] = held_kana;
                n++;
                held_valid = 0;
                held_kana = '0;
                held_marks = '0;
            end
            if (ansi && c >= hwfk_pkg::ASCII_FIRST && c <= hwfk_pkg::ASCII_LAST)
            begin
                outs[n] = fullwidth_ascii(c);
                n++;
            end
            else if (c >= hwfk_pkg::HALF_FIRST && c <= hwfk_pkg::HALF_LAST)
            begin
                idx = int'(c - hwfk_pkg::HALF_FIRST);
                m = kana_marks(idx);
                if (m != 2'b00 && !eot)
                begin
                    held_valid = 1;
                    held_kana = fullwidth_kana(idx);
                    held_marks = m;
                end
                else
                begin
                    outs[n] = fullwidth_kana(idx);
                    n++;
                end
            end
            else
            begin
                outs[n] = c;
                n++;
            end
            for (int i = 0; i < n; i++)
                pending.push_back('{outs[i], i == n - 1});
        endfunction

        function void check_result(input logic [15:0] code, input logic last);
            fw_unit_t exp_unit;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: code %h last %b", code, last);
                return;
            end
            exp_unit = pending.pop_front();
            if (code !== exp_unit.code || last !== exp_unit.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected code %h last %b, got code %h last %b",
                             exp_unit.code, exp_unit.last, code, last);
            end
        endfunction

        function void check_leftover();
            while (pending.size() != 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("missing transfer: code %h last %b",
                             pending[0].code, pending[0].last);
                void'(pending.pop_front());
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    kana_scoreboard sb;
    bit             calm = 0;
    int             sent;

    halfwidth_to_fullwidth_kana uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_unit(input logic [15:0] c, input logic eot);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= eot;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        sb.note_unit(c, eot);
    endtask

    // no result may still be in flight when a kana was just held
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_ansi(input logic val);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        sb.ansi = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_unit(inout int cnt);
        int          sel;
        int          idx;
        logic [15:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            // combinable kana followed mostly by a mark
            if ($urandom_range(0, 1) == 1)
                idx = $urandom_range(21, 35);
            else
                idx = $urandom_range(41, 45);
            send_unit(hwfk_pkg::HALF_FIRST + 16'(idx), 1'b0);
            if ($urandom_range(0, 3) == 0)
                c = 16'($urandom_range(0, 16'hFFFF));
            else if ($urandom_range(0, 1) == 1)
                c = hwfk_pkg::MARK_VOICED;
            else
                c = hwfk_pkg::MARK_SEMI;
            send_unit(c, $urandom_range(0, 7) == 0);
            cnt += 2;
            return;
        end
        if (sel < 60)
            c = hwfk_pkg::HALF_FIRST + 16'($urandom_range(0, 62));
        else if (sel < 75)
            c = 16'($urandom_range(hwfk_pkg::ASCII_FIRST, hwfk_pkg::ASCII_LAST));
        else if (sel < 85)
            c = 16'($urandom_range(0, 16'hFF));
        else
            c = 16'($urandom_range(0, 16'hFFFF));
        send_unit(c, $urandom_range(0, 9) == 0);
        cnt++;
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_ansi(1'b0);

        send_unit(16'h0000, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'h0020, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'hFF61, 1'b0);
        send_unit(16'hFF76, 1'b0);
        send_unit(hwfk_pkg::MARK_VOICED, 1'b0);
        send_unit(16'hFF8A, 1'b0);
        send_unit(hwfk_pkg::MARK_SEMI, 1'b0);
        send_unit(16'hFF84, 1'b0);
        send_unit(hwfk_pkg::MARK_SEMI, 1'b0);
        send_unit(16'hFF8E, 1'b1);
        send_unit(16'hFF8B, 1'b0);
        send_unit(hwfk_pkg::MARK_VOICED, 1'b1);
        send_unit(16'hFF71, 1'b0);
        send_unit(hwfk_pkg::MARK_VOICED, 1'b0);
        send_unit(16'hFF8C, 1'b0);
        send_unit(16'h0041, 1'b1);
        send_unit(16'hFF85, 1'b0);

        settle();
        write_ansi(1'b1);
        send_unit(16'h0020, 1'b0);
        send_unit(16'h0022, 1'b0);
        send_unit(16'h0027, 1'b0);
        send_unit(16'h002D, 1'b0);
        send_unit(16'h005C, 1'b0);
        send_unit(16'h007E, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'hFF7F, 1'b0);
        send_unit(16'h0041, 1'b1);

        for (int ph = 0; ph < 7; ph++)
        begin
            settle();
            write_ansi(ph[0]);
            if (ph == 6)
                calm = 1;
            sent = 0;
            while (sent < 100)
                random_unit(sent);
        end

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("halfwidth_to_fullwidth_kana verification clean");
        else
            $display("halfwidth_to_fullwidth_kana verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("halfwidth_to_fullwidth_kana verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/hwfk_pkg.sv
rtl/hwfk_conv.sv
rtl/halfwidth_to_fullwidth_kana.sv
sim/tb_halfwidth_to_fullwidth_kana.sv
